FILE: rtl/hid_boot_keyboard_report_tracker_macros.svh
// ----------------------------------------------------------------------------
// HID boot keyboard report tracker - assertion macros
// Concurrent checks on clk, disabled while rst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef HID_BOOT_KEYBOARD_REPORT_TRACKER_MACROS_SVH
`define HID_BOOT_KEYBOARD_REPORT_TRACKER_MACROS_SVH

`ifndef SYNTH
// condition must never hold
`define HBK_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
// consequent holds in the same cycle
`define HBK_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequent holds in the following cycle
`define HBK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HBK_ASSERT_NEVER(lbl, cond, msg)
`define HBK_ASSERT_IMPL(lbl, ante, cons, msg)
`define HBK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/hbk_pkg.sv
// ----------------------------------------------------------------------------
// hbk_pkg
// Shared types and constants of the HID boot keyboard report tracker.
// ----------------------------------------------------------------------------
package hbk_pkg;

    localparam int KEY_SLOTS_DEF = 6;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 24;
    localparam int REPORT_BYTES = 8;

    localparam logic [3:0]  REPORT_MAX_LEN  = 4'd9;
    localparam logic [3:0]  REPORT_ID_LEN   = 4'd8;
    localparam logic [15:0] HOLD_TIME_RESET = 16'd1000;
    localparam logic [15:0] MS_MAX          = 16'hFFFF;

    localparam logic [7:0] KEY_NONE     = 8'h00;
    localparam logic [7:0] KEY_ROLLOVER = 8'h01;
    localparam logic [7:0] MOD_LOWEST   = 8'h01;
    localparam logic [7:0] MOD_HIGHEST  = 8'h80;

    typedef logic [7:0] byte_t;

    typedef enum logic [2:0] {
        EV_MOD     = 3'd0,
        EV_DOWN    = 3'd1,
        EV_UP      = 3'd2,
        EV_OUTLINE = 3'd3,
        EV_SEND    = 3'd4,
        EV_NONE    = 3'd5
    } ev_kind_t;

    // per-slot findings of one lane
    typedef struct packed {
        logic down_ev;
        logic up_ev;
        logic new_active;
        logic old_active;
        logic old_is_held;
    } lane_res_t;

    // combined findings over all lanes and the whole report
    typedef struct packed {
        logic  diff;
        logic  new_empty;
        logic  old_sole_held;
        byte_t mods_new;
    } merge_res_t;

endpackage

FILE: rtl/hbk_lane.sv
// ----------------------------------------------------------------------------
// hbk_lane
// One key slot: compare the new and old slot values with every slot.
// ----------------------------------------------------------------------------
module hbk_lane #(
    parameter int NSLOT = hbk_pkg::KEY_SLOTS_DEF
) (
    input  hbk_pkg::byte_t    own_new,
    input  hbk_pkg::byte_t    own_old,
    input  hbk_pkg::byte_t    new_slots [NSLOT],
    input  hbk_pkg::byte_t    old_slots [NSLOT],
    input  hbk_pkg::byte_t    held_key,
    output hbk_pkg::lane_res_t res
);

    logic hit_new;
    logic hit_old;

    always_comb
    begin
        hit_new = 1'b0;
        hit_old = 1'b0;
        for (int j = 0; j < NSLOT; j++)
        begin
            if (own_new == old_slots[j])
            begin
                hit_new = 1'b1;
            end
            if (new_slots[j] == own_old)
            begin
                hit_old = 1'b1;
            end
        end
    end

    always_comb
    begin
        // a key that was nowhere before goes down, one that is gone goes up
        res.down_ev     = !(hit_new && (own_new != hbk_pkg::KEY_ROLLOVER)) &&
                          (own_new != hbk_pkg::KEY_NONE);
        res.up_ev       = !(hit_old && (own_old != hbk_pkg::KEY_ROLLOVER)) &&
                          (own_old != hbk_pkg::KEY_NONE);
        res.new_active  = (own_new != hbk_pkg::KEY_NONE) &&
                          (own_new != hbk_pkg::KEY_ROLLOVER);
        res.old_active  = (own_old != hbk_pkg::KEY_NONE) &&
                          (own_old != hbk_pkg::KEY_ROLLOVER);
        res.old_is_held = res.old_active && (own_old == held_key);
    end

endmodule

FILE: rtl/hbk_merge.sv
// ----------------------------------------------------------------------------
// hbk_merge
// Combine lane findings into event vectors and report-wide flags.
// ----------------------------------------------------------------------------
module hbk_merge #(
    parameter int NSLOT = hbk_pkg::KEY_SLOTS_DEF
) (
    input  hbk_pkg::lane_res_t  lane_res  [NSLOT],
    input  hbk_pkg::byte_t      new_bytes [hbk_pkg::REPORT_BYTES],
    input  hbk_pkg::byte_t      old_bytes [hbk_pkg::REPORT_BYTES],
    output logic [7:0]          down_vec,
    output logic [7:0]          up_vec,
    output hbk_pkg::merge_res_t mres
);

    logic [2:0] old_cnt;
    logic       any_new;
    logic       any_held;

    always_comb
    begin
        down_vec = '0;
        up_vec   = '0;
        old_cnt  = '0;
        any_new  = 1'b0;
        any_held = 1'b0;
        for (int i = 0; i < NSLOT; i++)
        begin
            down_vec[i] = lane_res[i].down_ev;
            up_vec[i]   = lane_res[i].up_ev;
            old_cnt     = old_cnt + 3'(lane_res[i].old_active);
            any_new     = any_new | lane_res[i].new_active;
            any_held    = any_held | lane_res[i].old_is_held;
        end
        mres.diff = 1'b0;
        for (int k = 0; k < hbk_pkg::REPORT_BYTES; k++)
        begin
            mres.diff = mres.diff | (new_bytes[k] != old_bytes[k]);
        end
        mres.new_empty     = !any_new;
        mres.old_sole_held = (old_cnt == 3'd1) && any_held;
        mres.mods_new      = new_bytes[0] & ~old_bytes[0];
    end

endmodule

FILE: rtl/hid_boot_keyboard_report_tracker.sv
// ----------------------------------------------------------------------------
// hid_boot_keyboard_report_tracker
// Key press / release event generator for USB HID boot keyboard reports.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: one item is either a keyboard report (s_tuser = 0) or a
//   one-millisecond tick (s_tuser = 1). Reports of up to nine bytes are
//   taken; a leading report ID is detected and stripped.
//   Master stream: event items, one per modifier press, key down, key up,
//   outline change or send key; m_tlast marks the final event of an item.
//   An item that raises nothing yields a single event of kind none.
//   cfg_wen / cfg_wdata write the hold time in ms; write only while idle.
// Sequence
//   A report walks a fixed sequence: the lane compare step, one step per
//   modifier bit, a key down and a key up step per key slot and an outline
//   step, then the final flush. A tick walks the lane, outline and send
//   steps, a rollover report only the lane step, before the flush. The next
//   item is taken in the same cycle as the last event of the current one is
//   registered at the flush. Each event waits in a pending stage until the
//   next event or the final flush moves it to the output register.
// Reset and stall
//   Reset clears all tracked state and loads a hold time of 1000 ms. A stalled
//   master side holds the flush, and any emitting step behind a pending event.
// ----------------------------------------------------------------------------
`include "hid_boot_keyboard_report_tracker_macros.svh"

module hid_boot_keyboard_report_tracker #(
    parameter int KEY_SLOTS = hbk_pkg::KEY_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration: hold time in milliseconds
    input  logic                           cfg_wen,
    input  logic [15:0]                    cfg_wdata,
    // slave stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // report_len[3:0], report_byte_0[11:4] ... report_byte_8[75:68], zero pad
    input  logic [hbk_pkg::IN_TDATA_W-1:0] s_tdata,
    // func[0]
    input  logic                           s_tuser,
    // master stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // event_modifiers[7:0], event_key[15:8], new_display[16], outline_on[17]
    output logic [hbk_pkg::OUT_TDATA_W-1:0] m_tdata,
    // event_kind[2:0]
    output logic [2:0]                     m_tuser,
    // last
    output logic                           m_tlast
);

    localparam int NSLOT = KEY_SLOTS;
    localparam int NB    = hbk_pkg::REPORT_BYTES;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LANE,
        PH_MOD,
        PH_DOWN,
        PH_UP,
        PH_HIDE,
        PH_TOUT,
        PH_TSEND,
        PH_END
    } phase_t;

    typedef struct packed {
        hbk_pkg::ev_kind_t kind;
        logic [7:0]        mods;
        logic [7:0]        key;
        logic              nd;
        logic              on;
    } ev_t;

    localparam ev_t EV_IDLE = '{kind: hbk_pkg::EV_NONE, mods: 8'h00, key: 8'h00,
                                nd: 1'b0, on: 1'b0};

    // ---------------------------------------------------------------- state
    phase_t         phase_reg;
    logic [2:0]     idx_reg;
    logic           func_reg;
    hbk_pkg::byte_t nr_reg       [NB];
    hbk_pkg::byte_t prev_reg     [NB];
    hbk_pkg::byte_t old_rep_reg  [NB];
    logic [7:0]     mods_new_reg;
    logic [7:0]     down_vec_reg;
    logic [7:0]     up_vec_reg;
    logic           empty_reg;
    logic           hide_reg;
    logic           fire_reg;
    logic [15:0]    hold_time_reg;
    logic [15:0]    ms_reg;
    logic [7:0]     disp_key_reg;
    logic [7:0]     disp_mods_reg;
    logic [7:0]     held_key_reg;
    logic [7:0]     held_mods_reg;
    logic           box_reg;
    logic           sent_reg;
    ev_t            pend_reg;
    logic           pend_valid_reg;
    ev_t            out_reg;
    logic           m_tvalid_reg;
    logic           m_tlast_reg;

    // ------------------------------------------------ input normalisation
    logic [3:0]     len_sat;
    hbk_pkg::byte_t raw [NB + 1];
    logic           has_id;
    hbk_pkg::byte_t nr_in [NB];

    always_comb
    begin
        len_sat = (s_tdata[3:0] > hbk_pkg::REPORT_MAX_LEN) ? hbk_pkg::REPORT_MAX_LEN
                                                            : s_tdata[3:0];
        // bytes past the received length read as zero
        for (int k = 0; k < NB + 1; k++)
        begin
            raw[k] = (4'(k) < len_sat) ? s_tdata[4 + 8*k +: 8] : hbk_pkg::KEY_NONE;
        end
        has_id = (len_sat == hbk_pkg::REPORT_MAX_LEN) ||
                 ((len_sat == hbk_pkg::REPORT_ID_LEN) && (raw[0] != 8'h00) &&
                  (raw[2] == 8'h00) && (raw[3] != 8'h00));
        for (int k = 0; k < NB; k++)
        begin
            nr_in[k] = has_id ? raw[k + 1] : raw[k];
        end
    end

    // ------------------------------------------------------------- lanes
    hbk_pkg::byte_t     new_slots [NSLOT];
    hbk_pkg::byte_t     old_slots [NSLOT];
    hbk_pkg::lane_res_t lane_res  [NSLOT];
    logic [7:0]         down_vec;
    logic [7:0]         up_vec;
    hbk_pkg::merge_res_t mres;

    for (genvar i = 0; i < NSLOT; i++)
    begin : g_lane
        assign new_slots[i] = nr_reg[i + 2];
        assign old_slots[i] = prev_reg[i + 2];

        hbk_lane #(
            .NSLOT (NSLOT)
        ) u_lane (
            .own_new   (nr_reg[i + 2]),
            .own_old   (prev_reg[i + 2]),
            .new_slots (new_slots),
            .old_slots (old_slots),
            .held_key  (held_key_reg),
            .res       (lane_res[i])
        );
    end

    hbk_merge #(
        .NSLOT (NSLOT)
    ) u_merge (
        .lane_res  (lane_res),
        .new_bytes (nr_reg),
        .old_bytes (prev_reg),
        .down_vec  (down_vec),
        .up_vec    (up_vec),
        .mres      (mres)
    );

    // ------------------------------------------------------ step decode
    logic [2:0]  slot_sel;
    logic [7:0]  slot_key;
    logic        is_new;
    logic        held_chg;
    logic        up_clear;
    logic [15:0] ms_inc;
    logic        fire;
    logic        step_emit;
    ev_t         ev;
    logic        out_free;
    logic        step_go;
    logic        end_go;
    logic        s_accept;

    always_comb
    begin
        slot_sel = idx_reg + 3'd2;
        slot_key = nr_reg[slot_sel];
        is_new   = (slot_key != disp_key_reg) || (nr_reg[0] != disp_mods_reg);
        held_chg = (slot_key != held_key_reg) || (nr_reg[0] != held_mods_reg);
        up_clear = (old_rep_reg[slot_sel] == held_key_reg) &&
                   (old_rep_reg[0] == held_mods_reg);
        ms_inc   = (ms_reg == hbk_pkg::MS_MAX) ? ms_reg : ms_reg + 16'd1;
        // a sole held key that is also on display and has stayed long enough
        fire     = (held_key_reg != hbk_pkg::KEY_NONE) &&
                   (held_key_reg == disp_key_reg) &&
                   (held_mods_reg == disp_mods_reg) &&
                   mres.old_sole_held && (ms_inc >= hold_time_reg);

        step_emit = 1'b0;
        ev        = EV_IDLE;
        unique case (phase_reg)
            PH_MOD:
            begin
                step_emit = mods_new_reg[idx_reg];
                ev.kind   = hbk_pkg::EV_MOD;
                ev.mods   = hbk_pkg::MOD_LOWEST << idx_reg;
            end
            PH_DOWN:
            begin
                step_emit = down_vec_reg[idx_reg];
                ev.kind   = hbk_pkg::EV_DOWN;
                ev.mods   = nr_reg[0];
                ev.key    = slot_key;
                ev.nd     = is_new;
            end
            PH_UP:
            begin
                step_emit = up_vec_reg[idx_reg];
                ev.kind   = hbk_pkg::EV_UP;
                ev.mods   = old_rep_reg[0];
                ev.key    = old_rep_reg[slot_sel];
            end
            PH_HIDE:
            begin
                step_emit = hide_reg;
                ev.kind   = hbk_pkg::EV_OUTLINE;
            end
            PH_TOUT:
            begin
                step_emit = fire_reg && !box_reg;
                ev.kind   = hbk_pkg::EV_OUTLINE;
                ev.on     = 1'b1;
            end
            PH_TSEND:
            begin
                step_emit = fire_reg && !sent_reg;
                ev.kind   = hbk_pkg::EV_SEND;
                ev.mods   = held_mods_reg;
                ev.key    = held_key_reg;
            end
            PH_IDLE, PH_LANE, PH_END:
            begin
                step_emit = 1'b0;
            end
            default:
            begin
                step_emit = 1'b0;
            end
        endcase

        out_free = !m_tvalid_reg || m_tready;
        // a step that emits needs the pending stage to be able to drain
        step_go  = (phase_reg != PH_IDLE) && (phase_reg != PH_END) &&
                   (!step_emit || !pend_valid_reg || out_free);
        end_go   = (phase_reg == PH_END) && out_free;
    end

    assign s_tready = (phase_reg == PH_IDLE) || end_go;
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------ sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            idx_reg        <= '0;
            func_reg       <= 1'b0;
            for (int k = 0; k < NB; k++)
            begin
                nr_reg[k]      <= '0;
                prev_reg[k]    <= '0;
                old_rep_reg[k] <= '0;
            end
            mods_new_reg   <= '0;
            down_vec_reg   <= '0;
            up_vec_reg     <= '0;
            empty_reg      <= 1'b0;
            hide_reg       <= 1'b0;
            fire_reg       <= 1'b0;
            hold_time_reg  <= hbk_pkg::HOLD_TIME_RESET;
            ms_reg         <= '0;
            disp_key_reg   <= '0;
            disp_mods_reg  <= '0;
            held_key_reg   <= '0;
            held_mods_reg  <= '0;
            box_reg        <= 1'b0;
            sent_reg       <= 1'b0;
            pend_reg       <= EV_IDLE;
            pend_valid_reg <= 1'b0;
            out_reg        <= EV_IDLE;
            m_tvalid_reg   <= 1'b0;
            m_tlast_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                hold_time_reg <= cfg_wdata;
            end

            // drop the output item once taken; reloads below override
            if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (step_go)
            begin
                unique case (phase_reg)
                    PH_LANE:
                    begin
                        if (func_reg)
                        begin
                            // tick: advance the hold timer, decide on send
                            ms_reg    <= ms_inc;
                            fire_reg  <= fire;
                            phase_reg <= PH_TOUT;
                        end
                        else if (nr_reg[2] == hbk_pkg::KEY_ROLLOVER)
                        begin
                            // rollover report: leave everything alone
                            phase_reg <= PH_END;
                        end
                        else
                        begin
                            mods_new_reg <= mres.mods_new;
                            down_vec_reg <= down_vec;
                            up_vec_reg   <= up_vec;
                            empty_reg    <= mres.new_empty;
                            hide_reg     <= mres.diff || mres.new_empty;
                            if (mres.diff)
                            begin
                                ms_reg <= '0;
                            end
                            if (mres.diff || mres.new_empty)
                            begin
                                box_reg <= 1'b0;
                            end
                            for (int k = 0; k < NB; k++)
                            begin
                                old_rep_reg[k] <= prev_reg[k];
                                prev_reg[k]    <= nr_reg[k];
                            end
                            idx_reg   <= '0;
                            phase_reg <= PH_MOD;
                        end
                    end
                    PH_MOD:
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            phase_reg <= PH_DOWN;
                        end
                    end
                    PH_DOWN:
                    begin
                        if (down_vec_reg[idx_reg])
                        begin
                            if (is_new)
                            begin
                                disp_key_reg  <= slot_key;
                                disp_mods_reg <= nr_reg[0];
                            end
                            if (held_chg)
                            begin
                                held_key_reg  <= slot_key;
                                held_mods_reg <= nr_reg[0];
                            end
                            if (is_new || held_chg)
                            begin
                                hide_reg <= 1'b1;
                                box_reg  <= 1'b0;
                            end
                        end
                        phase_reg <= PH_UP;
                    end
                    PH_UP:
                    begin
                        if (up_vec_reg[idx_reg] && up_clear)
                        begin
                            held_key_reg  <= '0;
                            held_mods_reg <= '0;
                        end
                        if (idx_reg == 3'(NSLOT - 1))
                        begin
                            phase_reg <= PH_HIDE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 3'd1;
                            phase_reg <= PH_DOWN;
                        end
                    end
                    PH_HIDE:
                    begin
                        // no key left: forget the held key and the send
                        if (empty_reg)
                        begin
                            held_key_reg  <= '0;
                            held_mods_reg <= '0;
                            sent_reg      <= 1'b0;
                        end
                        phase_reg <= PH_END;
                    end
                    PH_TOUT:
                    begin
                        if (fire_reg && !box_reg)
                        begin
                            box_reg <= 1'b1;
                        end
                        phase_reg <= PH_TSEND;
                    end
                    PH_TSEND:
                    begin
                        if (fire_reg && !sent_reg)
                        begin
                            sent_reg <= 1'b1;
                        end
                        phase_reg <= PH_END;
                    end
                    default:
                    begin
                        phase_reg <= phase_reg;
                    end
                endcase

                // push the pending event out and hold the new one back
                if (step_emit)
                begin
                    if (pend_valid_reg)
                    begin
                        out_reg      <= pend_reg;
                        m_tlast_reg  <= 1'b0;
                        m_tvalid_reg <= 1'b1;
                    end
                    pend_reg       <= ev;
                    pend_valid_reg <= 1'b1;
                end
            end

            if (end_go)
            begin
                out_reg        <= pend_valid_reg ? pend_reg : EV_IDLE;
                m_tlast_reg    <= 1'b1;
                m_tvalid_reg   <= 1'b1;
                pend_valid_reg <= 1'b0;
                phase_reg      <= PH_IDLE;
            end

            if (s_accept)
            begin
                func_reg <= s_tuser;
                for (int k = 0; k < NB; k++)
                begin
                    nr_reg[k] <= nr_in[k];
                end
                phase_reg <= PH_LANE;
            end
        end
    end

    // ------------------------------------------------------------ outputs
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'd0, out_reg.on, out_reg.nd, out_reg.key, out_reg.mods};

    // ---------------------------------------------------------- assertions
    `HBK_ASSERT_NEVER(a_pend_idle, (phase_reg == PH_IDLE) && pend_valid_reg, "pending event left while idle")
    `HBK_ASSERT_NEXT(a_end_last, end_go, m_tvalid && m_tlast, "final flush without a last item")
    `HBK_ASSERT_IMPL(a_held_pair, held_key_reg == hbk_pkg::KEY_NONE, held_mods_reg == 8'h00, "held modifiers without held key")

endmodule

FILE: tb/sv/hid_boot_keyboard_report_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_boot_keyboard_report_tracker_tb
// Self-checking bench for the boot keyboard report tracker. Keyboard reports
// and millisecond ticks go in on the slave stream. A predictor of the key
// diffing and the hold timer works out the events of each accepted item, and
// every event leaving the master stream is compared field by field with the
// oldest prediction. Directed items cover report ID detection, rollover,
// length handling and the timer; random traffic follows, with both streams
// stalling at random outside one phase.
// ----------------------------------------------------------------------------
module hid_boot_keyboard_report_tracker_tb;

    import hbk_pkg::*;

    localparam int          NUM_SLOTS     = KEY_SLOTS_DEF;
    localparam int          SETTLE_CYCLES = 30;
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    // one slave item: func travels on tuser, the rest packed into tdata
    typedef struct packed {
        logic            func;
        logic [3:0]      len;
        logic [8:0][7:0] raw;
    } tracker_item_t;

    // one master item, as predicted
    typedef struct {
        ev_kind_t kind;
        byte_t    mods;
        byte_t    key;
        logic     new_display;
        logic     outline_on;
        logic     last;
    } tracker_event_t;

    // normalised eight-byte boot report, byte i at index i
    typedef logic [7:0][7:0] boot_report_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wen   = 1'b0;
    logic [15:0]            cfg_wdata = 16'd0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [2:0]             m_tuser;
    logic                   m_tlast;

    // predictor state
    logic [15:0]  hold_ms;
    boot_report_t last_report;
    byte_t        last_mods;
    byte_t        shown_key;
    byte_t        shown_mods;
    byte_t        held_key;
    byte_t        held_mods;
    logic         box_on;
    logic         sent_flag;
    logic [15:0]  ms_count;

    tracker_event_t item_events[$];
    tracker_event_t expected_events[$];
    tracker_event_t oldest_event;

    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          no_idle        = 1'b0;

    hid_boot_keyboard_report_tracker #(
        .KEY_SLOTS (NUM_SLOTS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Guard against a hung block: end the run as failed.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Slots holding 0x00 or 0x01 do not count as pressed keys.
    function automatic int live_keys(boot_report_t rep);
        int c = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (rep[2 + i] != KEY_NONE && rep[2 + i] != KEY_ROLLOVER)
                c++;
        return c;
    endfunction

    function automatic logic only_key_is(boot_report_t rep, byte_t key);
        if (live_keys(rep) != 1)
            return 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (rep[2 + i] != KEY_NONE && rep[2 + i] != KEY_ROLLOVER)
                return rep[2 + i] == key;
        return 1'b0;
    endfunction

    function automatic void add_event(ev_kind_t kind, byte_t mods, byte_t key,
                                      logic nd, logic on);
        tracker_event_t ev;
        ev.kind        = kind;
        ev.mods        = mods;
        ev.key         = key;
        ev.new_display = nd;
        ev.outline_on  = on;
        ev.last        = 1'b0;
        item_events.push_back(ev);
    endfunction

    function automatic void track_report(tracker_item_t it);
        logic [3:0]      len;
        logic [8:0][7:0] rb;
        boot_report_t    nr;
        byte_t           mods;
        byte_t           key;
        byte_t           pm;
        logic            hide;
        logic            down;
        logic            up;
        logic            fresh;

        len = (it.len > REPORT_MAX_LEN) ? REPORT_MAX_LEN : it.len;
        // bytes at or past the length read as zero
        for (int i = 0; i < 9; i++)
            rb[i] = (i < len) ? it.raw[i] : 8'h00;
        // strip a report ID: always at nine bytes, and at eight bytes when
        // the layout only makes sense shifted by one
        if (len > REPORT_ID_LEN ||
            (len == REPORT_ID_LEN && rb[0] != 8'h00 && rb[2] == 8'h00 && rb[3] != 8'h00))
            for (int i = 0; i < REPORT_BYTES; i++)
                nr[i] = rb[i + 1];
        else
            for (int i = 0; i < REPORT_BYTES; i++)
                nr[i] = rb[i];

        // rollover report: leave every piece of state alone
        if (nr[2] == KEY_ROLLOVER)
            return;

        hide = 1'b0;
        mods = nr[0];
        if (mods != last_mods)
        begin
            for (int b = 0; b < 8; b++)
                if (!last_mods[b] && mods[b])
                    add_event(EV_MOD, MOD_LOWEST << b, KEY_NONE, 1'b0, 1'b0);
            last_mods = mods;
        end

        for (int i = 2; i < 2 + NUM_SLOTS; i++)
        begin
            down = 1'b0;
            up   = 1'b0;
            for (int j = 2; j < 2 + NUM_SLOTS; j++)
            begin
                if (nr[i] == last_report[j] && nr[i] != KEY_ROLLOVER)
                    down = 1'b1;
                if (nr[j] == last_report[i] && last_report[i] != KEY_ROLLOVER)
                    up = 1'b1;
            end
            if (!down && nr[i] != KEY_NONE)
            begin
                key   = nr[i];
                fresh = (key != shown_key) || (mods != shown_mods);
                if (fresh)
                begin
                    shown_key  = key;
                    shown_mods = mods;
                    box_on     = 1'b0;
                    hide       = 1'b1;
                end
                if (held_key != key || held_mods != mods)
                begin
                    held_key  = key;
                    held_mods = mods;
                    if (!fresh)
                    begin
                        box_on = 1'b0;
                        hide   = 1'b1;
                    end
                end
                add_event(EV_DOWN, mods, key, fresh, 1'b0);
            end
            if (!up && last_report[i] != KEY_NONE)
            begin
                key = last_report[i];
                pm  = last_report[0];
                if (key == held_key && pm == held_mods)
                begin
                    held_key  = KEY_NONE;
                    held_mods = 8'h00;
                end
                add_event(EV_UP, pm, key, 1'b0, 1'b0);
            end
        end

        // any change restarts the hold timer
        if (nr != last_report)
        begin
            ms_count = 16'd0;
            box_on   = 1'b0;
            hide     = 1'b1;
        end
        last_report = nr;

        if (live_keys(nr) == 0)
        begin
            held_key  = KEY_NONE;
            held_mods = 8'h00;
            box_on    = 1'b0;
            sent_flag = 1'b0;
            hide      = 1'b1;
        end
        // all hide requests of one report merge into one trailing event
        if (hide)
            add_event(EV_OUTLINE, 8'h00, KEY_NONE, 1'b0, 1'b0);
    endfunction

    function automatic void track_tick();
        if (ms_count != MS_MAX)
            ms_count = ms_count + 16'd1;
        if (held_key == KEY_NONE || held_key != shown_key || held_mods != shown_mods)
            return;
        if (!only_key_is(last_report, held_key))
            return;
        if (ms_count < hold_ms)
            return;
        if (!box_on)
        begin
            box_on = 1'b1;
            add_event(EV_OUTLINE, 8'h00, KEY_NONE, 1'b0, 1'b1);
        end
        if (sent_flag)
            return;
        sent_flag = 1'b1;
        add_event(EV_SEND, held_mods, held_key, 1'b0, 1'b0);
    endfunction

    // Work out the events of one accepted item and queue them, last marked.
    function automatic void predict_item(tracker_item_t it);
        tracker_event_t ev;
        item_events.delete();
        if (it.func)
            track_tick();
        else
            track_report(it);
        if (item_events.size() == 0)
            add_event(EV_NONE, 8'h00, KEY_NONE, 1'b0, 1'b0);
        for (int k = 0; k < item_events.size(); k++)
        begin
            ev      = item_events[k];
            ev.last = (k == item_events.size() - 1);
            expected_events.push_back(ev);
        end
    endfunction

    function automatic void reset_tracker();
        hold_ms     = HOLD_TIME_RESET;
        last_report = '0;
        last_mods   = 8'h00;
        shown_key   = KEY_NONE;
        shown_mods  = 8'h00;
        held_key    = KEY_NONE;
        held_mods   = 8'h00;
        box_on      = 1'b0;
        sent_flag   = 1'b0;
        ms_count    = 16'd0;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking and master-side stalls
    // ------------------------------------------------------------------------

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        // stall the master side in about a quarter of the cycles
        m_tready <= no_idle || ($urandom_range(99) >= 26);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_events.size() == 0)
            begin
                $error("event: expected none, got kind %0d", m_tuser);
                mismatch_count++;
            end
            else
            begin
                oldest_event = expected_events.pop_front();
                check_field("event_kind", oldest_event.kind, m_tuser);
                check_field("event_modifiers", oldest_event.mods, m_tdata[7:0]);
                check_field("event_key", oldest_event.key, m_tdata[15:8]);
                check_field("new_display", oldest_event.new_display, m_tdata[16]);
                check_field("outline_on", oldest_event.outline_on, m_tdata[17]);
                check_field("last", oldest_event.last, m_tlast);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item builders and shared tasks
    // ------------------------------------------------------------------------

    function automatic tracker_item_t boot_report(byte_t mods, byte_t k0 = 8'h00,
                                                  byte_t k1 = 8'h00, byte_t k2 = 8'h00,
                                                  byte_t k3 = 8'h00, byte_t k4 = 8'h00,
                                                  byte_t k5 = 8'h00);
        tracker_item_t it;
        it.func   = 1'b0;
        it.len    = REPORT_ID_LEN;
        it.raw    = '0;
        it.raw[0] = mods;
        it.raw[2] = k0;
        it.raw[3] = k1;
        it.raw[4] = k2;
        it.raw[5] = k3;
        it.raw[6] = k4;
        it.raw[7] = k5;
        return it;
    endfunction

    // Prepend a report ID and make the item nine bytes long.
    function automatic tracker_item_t with_report_id(tracker_item_t it, byte_t id);
        it.raw = {it.raw[7:0], id};
        it.len = REPORT_MAX_LEN;
        return it;
    endfunction

    // Ticks carry random data, which the block must ignore.
    function automatic tracker_item_t tick_item();
        tracker_item_t it;
        it.func = 1'b1;
        it.len  = 4'($urandom_range(15));
        for (int i = 0; i < 9; i++)
            it.raw[i] = byte_t'($urandom_range(255));
        return it;
    endfunction

    // Present one item, hold it until accepted, then predict its events.
    task automatic send_item(input tracker_item_t it);
        if (!no_idle && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 26)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {4'b0000, it.raw, it.len};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(it);
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++)
            send_item(tick_item());
    endtask

    // Drop valid and wait until every predicted event has left the block.
    task automatic drain_events();
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_hold_time(input logic [15:0] value);
        drain_events();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        hold_ms = value;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The reset hold time is 1000 ms: a sole key is sent on the 1000th tick.
    task automatic test_reset_hold_time();
        send_item(tick_item());
        send_item(boot_report(8'h00, 8'h04));
        send_ticks(1001);
    endtask

    task automatic test_report_decoding();
        tracker_item_t it;
        send_item(boot_report(8'h00));
        send_item(boot_report(MOD_LOWEST, 8'h04));
        send_item(boot_report(MOD_HIGHEST, 8'h04));
        send_item(boot_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
        // every modifier pressed, every slot replaced: the longest burst
        send_item(boot_report(8'hFF, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F));
        // highest usage code, and a 0x01 slot that is not a key
        send_item(boot_report(8'h00, 8'hFF, KEY_ROLLOVER));
        // rollover report
        send_item(boot_report(8'h02, KEY_ROLLOVER, KEY_ROLLOVER, KEY_ROLLOVER,
                              KEY_ROLLOVER, KEY_ROLLOVER, KEY_ROLLOVER));
        // nine bytes with report ID, last slot in byte 8
        send_item(with_report_id(boot_report(8'h02, 8'h00, 8'h1E, 8'h00, 8'h00,
                                             8'h00, 8'h2C), 8'h03));
        // eight bytes that read as a report ID followed by a short report
        send_item(boot_report(8'h01, 8'h00, 8'h20));
        // oversize length saturates to nine
        it     = with_report_id(boot_report(8'h10, 8'h21, 8'h22), 8'hFF);
        it.len = 4'hF;
        send_item(it);
        // zero length: every byte reads as zero
        it     = boot_report(8'hFF, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66);
        it.len = 4'd0;
        send_item(it);
        // short report: only the first three bytes count
        it     = boot_report(8'h02, 8'h1F, 8'h20, 8'h21);
        it.len = 4'd3;
        send_item(it);
        // byte 0 set, bytes 2 and 3 clear: no report ID
        send_item(boot_report(8'h04, 8'h00, 8'h00, 8'h21));
        send_item(tick_item());
    endtask

    task automatic test_hold_timer();
        // zero hold time: the first tick after a sole key sends it
        write_hold_time(16'd0);
        send_item(boot_report(8'h00, 8'h04));
        send_ticks(2);
        send_item(boot_report(8'h00, 8'h04));
        send_item(boot_report(8'h00, 8'h04, 8'h05));
        send_item(tick_item());
        // second key left alone after the first is released: box only,
        // since the send flag clears on an empty report alone
        send_item(boot_report(8'h00, 8'h00, 8'h05));
        send_item(tick_item());
        send_item(boot_report(8'h00));
        send_item(tick_item());
        // held key with a modifier
        write_hold_time(16'd1);
        send_item(boot_report(8'h02, 8'h2A));
        send_ticks(2);
        // longest hold time: nothing is sent within a few ticks
        write_hold_time(16'hFFFF);
        send_item(boot_report(8'h00, 8'h3A));
        send_ticks(2);
    endtask

    // Mostly well-formed key sequences, plus rollover, repeats and noise.
    task automatic test_random_traffic();
        tracker_item_t    it;
        logic [5:0][7:0]  keys;
        byte_t            mods;
        logic [15:0]      phase_hold;
        int               count;
        int               pick;
        int               ticks;
        bit               sole;

        keys = '0;
        mods = 8'h00;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       phase_hold = 16'd2;
                1:       phase_hold = 16'd0;
                2:       phase_hold = 16'($urandom_range(1, 12));
                default: phase_hold = 16'd6;
            endcase
            write_hold_time(phase_hold);
            // one phase runs with both streams never idling
            no_idle = (phase == 2);
            count = 0;
            while (count < 78)
            begin
                pick = $urandom_range(99);
                sole = 1'b0;
                if (pick < 25)
                    keys[$urandom_range(5)] = ($urandom_range(3) == 0) ?
                        byte_t'($urandom_range(2, 255)) : byte_t'($urandom_range(4, 11));
                else if (pick < 38)
                    keys[$urandom_range(5)] = KEY_NONE;
                else if (pick < 46)
                    keys = '0;
                else if (pick < 58)
                begin
                    keys = '0;
                    keys[$urandom_range(5)] = byte_t'($urandom_range(4, 11));
                    sole = 1'b1;
                end
                else if (pick < 68)
                    mods = ($urandom_range(1) == 0) ? (mods ^ (MOD_LOWEST << $urandom_range(7)))
                                                    : byte_t'($urandom_range(255));

                if (pick < 80)
                begin
                    it = boot_report(mods, keys[0], keys[1], keys[2], keys[3], keys[4],
                                     keys[5]);
                    if (pick >= 68)
                        it = boot_report(mods, KEY_ROLLOVER, KEY_ROLLOVER, KEY_ROLLOVER,
                                         KEY_ROLLOVER, KEY_ROLLOVER, KEY_ROLLOVER);
                    if ($urandom_range(99) < 15)
                    begin
                        it     = with_report_id(it, byte_t'($urandom_range(1, 255)));
                        it.len = 4'($urandom_range(9, 15));
                    end
                end
                else if (pick < 88)
                    it = boot_report(mods, keys[0], keys[1], keys[2], keys[3], keys[4],
                                     keys[5]);
                else
                begin
                    // noise: random length and bytes
                    it.func = 1'b0;
                    it.len  = 4'($urandom_range(15));
                    for (int i = 0; i < 9; i++)
                        it.raw[i] = byte_t'($urandom_range(255));
                end
                send_item(it);
                count++;

                // after a sole key, tick for the hold time and up to three more
                ticks = sole ? int'(phase_hold) + $urandom_range(3)
                             : (($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0);
                send_ticks(ticks);
                count += ticks;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        reset_tracker();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_hold_time();
        test_report_decoding();
        test_hold_timer();
        test_random_traffic();
        drain_events();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/hbk_pkg.sv
rtl/hbk_lane.sv
rtl/hbk_merge.sv
rtl/hid_boot_keyboard_report_tracker.sv
tb/sv/hid_boot_keyboard_report_tracker_tb.sv
